@@ hw/rtl/tmpd_pkg.sv @@
// Shared types and constants of the trace metadata packet deframer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tmpd_pkg;

    // Header layout
    localparam logic [5:0]  HDR_LAST_POS   = 6'd36;  // 37-byte header, positions 0..36
    localparam logic [5:0]  POS_UUID_FIRST = 6'd4;
    localparam logic [5:0]  POS_UUID_SPLIT = 6'd12;
    localparam logic [5:0]  POS_UUID_END   = 6'd20;
    localparam logic [5:0]  POS_CHECK_WORD = 6'd23;
    localparam logic [5:0]  POS_CONTENT_SZ = 6'd27;
    localparam logic [5:0]  POS_PACKET_SZ  = 6'd31;
    localparam logic [5:0]  POS_SCHEMES    = 6'd32;
    localparam logic [28:0] HDR_BYTES      = 29'd37;
    localparam int unsigned NUM_SCHEMES    = 5;

    // Scheme byte slots
    localparam logic [2:0] SCH_COMPRESSION = 3'd0;
    localparam logic [2:0] SCH_ENCRYPTION  = 3'd1;
    localparam logic [2:0] SCH_CHECKSUM    = 3'd2;
    localparam logic [2:0] SCH_MAJOR       = 3'd3;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_CONTENT = 4'b0010,
        PH_PAD     = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER  = 3'd0;
    localparam logic [2:0] ERR_COMPRESSION   = 3'd1;
    localparam logic [2:0] ERR_ENCRYPTION    = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM      = 3'd3;
    localparam logic [2:0] ERR_VERSION       = 3'd4;
    localparam logic [2:0] ERR_UUID          = 3'd5;
    localparam logic [2:0] ERR_SIZE          = 3'd6;
    localparam logic [2:0] ERR_SHORT_CONTENT = 3'd7;

    localparam logic [1:0] UUID_LEARN  = 2'd1;
    localparam logic [1:0] UUID_PRESET = 2'd2;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_BIG_ENDIAN  = 3'd0;
    localparam logic [2:0] REG_VER_MAJOR   = 3'd1;
    localparam logic [2:0] REG_VER_MINOR   = 3'd2;
    localparam logic [2:0] REG_UUID_MODE   = 3'd3;
    localparam logic [2:0] REG_UUID_HIGH   = 3'd4;
    localparam logic [2:0] REG_UUID_LOW    = 3'd5;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef struct packed {
        logic        header_big_endian;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [1:0]  uuid_mode;
        logic [63:0] preset_uuid_high;
        logic [63:0] preset_uuid_low;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } result_t;

    // Up to two results per input transaction; second only with the first
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_push_t;

endpackage

`default_nettype wire

@@ hw/rtl/trace_metadata_packet_deframer.sv @@
// Trace metadata packet deframer, top level. Instantiates tmpd_cfg, tmpd_core
// and tmpd_fifo; all types and constants come from tmpd_pkg.
//
// The block takes a packetized metadata byte stream, one byte per transaction,
// checks each 37-byte packet header and passes on the content bytes while it
// drops header and padding. It sustains one input byte per cycle while input
// ready is high: a byte is registered, processed the following cycle and its
// results (one content byte, a done/error result, or a content byte followed
// by a done or short-content error result) land in a four-entry result queue.
// Input ready falls when the queue could not take the worst case of the byte
// in flight plus a new one: when the output side has stalled, or while a
// stream-closing byte is in flight and the queue is not empty. The first error
// or the end of the stream halts the block; further bytes are taken and dropped
// until reset. The user must write registers through the APB port only while
// the block is idle; the block does not enforce this. They lie at byte address 8 * index.
`default_nettype none

module trace_metadata_packet_deframer
    import tmpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic      [1:0]  m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,   // last
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    cfg_t                  cfg;
    res_push_t             push;
    result_t               head;
    logic                  head_valid;
    logic [FIFO_CNT_W-1:0] fifo_count;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_eos_reg;
    logic [FIFO_CNT_W:0]   pending;
    logic [FIFO_CNT_W:0]   room_need;
    logic                  s_accept;

    // Worst-case results still to be pushed by the byte held in the input
    // register: two only when it closes the stream.
    assign pending   = in_valid_reg ? (in_eos_reg ? (FIFO_CNT_W+1)'(2) : (FIFO_CNT_W+1)'(1))
                                    : '0;
    // Leave room for that byte and for two more from the one being accepted
    assign room_need = {1'b0, fifo_count} + pending + (FIFO_CNT_W+1)'(2);
    assign s_axis_tready = room_need <= (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register: holds the accepted transaction for the core to process
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    tmpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmpd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_eos   (in_eos_reg),
        .push     (push)
    );

    tmpd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_axis_tready),
        .head_valid (head_valid),
        .head       (head),
        .count      (fifo_count)
    );

    // Drive the result channel straight from the queue head
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {5'b0, head.error_code, head.out_byte};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/tmpd_cfg.sv @@
// Configuration register file of the deframer, APB-style write/read port.
// Depends on tmpd_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module tmpd_cfg
    import tmpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_big_endian <= 1'b0;
            cfg_reg.version_major     <= 8'd1;
            cfg_reg.version_minor     <= 8'd8;
            cfg_reg.uuid_mode         <= UUID_LEARN;
            cfg_reg.preset_uuid_high  <= '0;
            cfg_reg.preset_uuid_low   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BIG_ENDIAN: cfg_reg.header_big_endian <= pwdata[0];
                REG_VER_MAJOR:  cfg_reg.version_major     <= pwdata[7:0];
                REG_VER_MINOR:  cfg_reg.version_minor     <= pwdata[7:0];
                REG_UUID_MODE:  cfg_reg.uuid_mode         <= pwdata[1:0];
                REG_UUID_HIGH:  cfg_reg.preset_uuid_high  <= pwdata;
                REG_UUID_LOW:   cfg_reg.preset_uuid_low   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIG_ENDIAN: prdata = {63'b0, cfg_reg.header_big_endian};
            REG_VER_MAJOR:  prdata = {56'b0, cfg_reg.version_major};
            REG_VER_MINOR:  prdata = {56'b0, cfg_reg.version_minor};
            REG_UUID_MODE:  prdata = {62'b0, cfg_reg.uuid_mode};
            REG_UUID_HIGH:  prdata = cfg_reg.preset_uuid_high;
            REG_UUID_LOW:   prdata = cfg_reg.preset_uuid_low;
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tmpd_core.sv @@
// Deframing engine: header capture and checks, content/padding counting.
// Depends on tmpd_pkg; fed from the input register, pushes into tmpd_fifo.
`default_nettype none

module tmpd_core
    import tmpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_eos,
    output res_push_t       push
);

    phase_t       phase_reg, phase_next;
    logic [5:0]   header_count_reg, header_count_next;
    logic [31:0]  word_acc_reg, word_acc_next;
    logic [31:0]  check_word_reg, check_word_next;
    logic [31:0]  content_bits_reg, content_bits_next;
    logic [31:0]  packet_bits_reg, packet_bits_next;
    logic [7:0]   scheme_reg [NUM_SCHEMES];
    logic [7:0]   scheme_next [NUM_SCHEMES];
    logic [63:0]  pkt_uuid_hi_reg, pkt_uuid_hi_next;
    logic [63:0]  pkt_uuid_lo_reg, pkt_uuid_lo_next;
    logic [63:0]  str_uuid_hi_reg, str_uuid_hi_next;
    logic [63:0]  str_uuid_lo_reg, str_uuid_lo_next;
    logic         uuid_known_reg, uuid_known_next;
    logic [28:0]  bytes_left_reg, bytes_left_next;
    // Sizes worked out early in the scheme bytes
    logic [28:0]  pad_bytes_reg, pad_bytes_next;
    logic         pad_zero_reg, pad_zero_next;
    logic [28:0]  content_left_reg, content_left_next;
    logic         content_left_zero_reg, content_left_zero_next;
    logic         content_short_reg, content_short_next;

    logic [31:0]  acc_base;
    logic [31:0]  acc_new;
    logic [31:0]  size_diff;
    logic [28:0]  content_bytes;
    logic [28:0]  left_calc;
    logic         hdr_fail;
    logic [2:0]   hdr_code;
    logic         uuid_bad;
    logic         emitted;
    result_t      eos_res;

    always_comb begin
        phase_next             = phase_reg;
        header_count_next      = header_count_reg;
        word_acc_next          = word_acc_reg;
        check_word_next        = check_word_reg;
        content_bits_next      = content_bits_reg;
        packet_bits_next       = packet_bits_reg;
        scheme_next            = scheme_reg;
        pkt_uuid_hi_next       = pkt_uuid_hi_reg;
        pkt_uuid_lo_next       = pkt_uuid_lo_reg;
        str_uuid_hi_next       = str_uuid_hi_reg;
        str_uuid_lo_next       = str_uuid_lo_reg;
        uuid_known_next        = uuid_known_reg;
        bytes_left_next        = bytes_left_reg;
        pad_bytes_next         = pad_bytes_reg;
        pad_zero_next          = pad_zero_reg;
        content_left_next      = content_left_reg;
        content_left_zero_next = content_left_zero_reg;
        content_short_next     = content_short_reg;
        push                   = '0;
        hdr_fail               = 1'b0;
        hdr_code               = ERR_NONE;
        uuid_bad               = 1'b0;
        emitted                = 1'b0;
        eos_res                = '0;

        // Word assembly of the header's 32-bit fields
        acc_base = (header_count_reg[1:0] == 2'd0) ? 32'd0 : word_acc_reg;
        if (cfg.header_big_endian) begin
            acc_new = {acc_base[23:0], in_byte};
        end else begin
            acc_new = acc_base | ({24'b0, in_byte} << {header_count_reg[1:0], 3'b000});
        end

        // Size arithmetic from the registered size words
        content_bytes = content_bits_reg[31:3];
        left_calc     = content_bytes - HDR_BYTES;
        size_diff     = packet_bits_reg - content_bits_reg;

        if (in_valid && phase_reg != PH_HALT) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (header_count_reg < POS_SCHEMES) begin
                        word_acc_next = acc_new;
                        if (header_count_reg >= POS_UUID_FIRST &&
                            header_count_reg < POS_UUID_END) begin
                            if (header_count_reg < POS_UUID_SPLIT) begin
                                pkt_uuid_hi_next = {pkt_uuid_hi_reg[55:0], in_byte};
                            end else begin
                                pkt_uuid_lo_next = {pkt_uuid_lo_reg[55:0], in_byte};
                            end
                        end else if (header_count_reg == POS_CHECK_WORD) begin
                            check_word_next = acc_new;
                        end else if (header_count_reg == POS_CONTENT_SZ) begin
                            content_bits_next = acc_new;
                        end else if (header_count_reg == POS_PACKET_SZ) begin
                            packet_bits_next = acc_new;
                        end
                    end else begin
                        scheme_next[header_count_reg[2:0]] = in_byte;
                    end

                    // Size words are complete from the first scheme byte on
                    if (header_count_reg == POS_SCHEMES) begin
                        content_short_next     = content_bytes < HDR_BYTES;
                        content_left_next      = left_calc;
                        content_left_zero_next = left_calc == '0;
                        if (packet_bits_reg >= content_bits_reg) begin
                            pad_bytes_next = size_diff[31:3];
                        end else begin
                            pad_bytes_next = '0;
                        end
                        pad_zero_next = !(packet_bits_reg >= content_bits_reg) ||
                                        size_diff[31:3] == '0;
                    end

                    if (header_count_reg == HDR_LAST_POS) begin
                        header_count_next = '0;
                        if (cfg.uuid_mode == UUID_LEARN) begin
                            uuid_bad = uuid_known_reg &&
                                       (pkt_uuid_hi_reg != str_uuid_hi_reg ||
                                        pkt_uuid_lo_reg != str_uuid_lo_reg);
                        end else if (cfg.uuid_mode == UUID_PRESET) begin
                            uuid_bad = pkt_uuid_hi_reg != cfg.preset_uuid_high ||
                                       pkt_uuid_lo_reg != cfg.preset_uuid_low;
                        end
                        priority if (scheme_reg[SCH_COMPRESSION] != 8'd0) begin
                            hdr_fail = 1'b1;
                            hdr_code = ERR_COMPRESSION;
                        end else if (scheme_reg[SCH_ENCRYPTION] != 8'd0) begin
                            hdr_fail = 1'b1;
                            hdr_code = ERR_ENCRYPTION;
                        end else if (check_word_reg != 32'd0 ||
                                     scheme_reg[SCH_CHECKSUM] != 8'd0) begin
                            hdr_fail = 1'b1;
                            hdr_code = ERR_CHECKSUM;
                        end else if (scheme_reg[SCH_MAJOR] != cfg.version_major ||
                                     in_byte != cfg.version_minor) begin
                            hdr_fail = 1'b1;
                            hdr_code = ERR_VERSION;
                        end else if (uuid_bad) begin
                            hdr_fail = 1'b1;
                            hdr_code = ERR_UUID;
                        end else begin
                            // Learn the stream uuid from the first packet to get here
                            if (cfg.uuid_mode == UUID_LEARN && !uuid_known_reg) begin
                                str_uuid_hi_next = pkt_uuid_hi_reg;
                                str_uuid_lo_next = pkt_uuid_lo_reg;
                                uuid_known_next  = 1'b1;
                            end
                            if (content_short_reg) begin
                                hdr_fail = 1'b1;
                                hdr_code = ERR_SIZE;
                            end
                        end

                        if (hdr_fail) begin
                            push.v0            = 1'b1;
                            push.r0.kind       = KIND_ERROR;
                            push.r0.error_code = hdr_code;
                            push.r0.last       = 1'b1;
                            phase_next         = PH_HALT;
                        end else if (!content_left_zero_reg) begin
                            bytes_left_next = content_left_reg;
                            phase_next      = PH_CONTENT;
                        end else begin
                            bytes_left_next = pad_bytes_reg;
                            phase_next      = pad_zero_reg ? PH_HEADER : PH_PAD;
                        end
                    end else begin
                        header_count_next = header_count_reg + 6'd1;
                    end
                end
                PH_CONTENT: begin
                    emitted          = 1'b1;
                    push.v0          = 1'b1;
                    push.r0.kind     = KIND_DATA;
                    push.r0.out_byte = in_byte;
                    if (bytes_left_reg == 29'd1) begin
                        bytes_left_next = pad_bytes_reg;
                        phase_next      = pad_zero_reg ? PH_HEADER : PH_PAD;
                    end else begin
                        bytes_left_next = bytes_left_reg - 29'd1;
                    end
                end
                PH_PAD: begin
                    bytes_left_next = bytes_left_reg - 29'd1;
                    if (bytes_left_reg == 29'd1) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HALT: ;
                default: ;
            endcase

            // Close the stream on its last byte
            if (in_eos && !hdr_fail) begin
                eos_res.last = 1'b1;
                if (phase_next == PH_HEADER && header_count_next != '0) begin
                    eos_res.kind       = KIND_ERROR;
                    eos_res.error_code = ERR_SHORT_HEADER;
                end else if (phase_next == PH_CONTENT) begin
                    eos_res.kind       = KIND_ERROR;
                    eos_res.error_code = ERR_SHORT_CONTENT;
                end else begin
                    eos_res.kind = KIND_DONE;
                end
                if (emitted) begin
                    push.v1 = 1'b1;
                    push.r1 = eos_res;
                end else begin
                    push.v0 = 1'b1;
                    push.r0 = eos_res;
                end
                phase_next = PH_HALT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            uuid_known_reg   <= 1'b0;
            check_word_reg   <= '0;
            content_bits_reg <= '0;
            packet_bits_reg  <= '0;
            bytes_left_reg   <= '0;
            pkt_uuid_hi_reg  <= '0;
            pkt_uuid_lo_reg  <= '0;
            for (int i = 0; i < NUM_SCHEMES; i++) begin
                scheme_reg[i] <= '0;
            end
        end else begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            uuid_known_reg   <= uuid_known_next;
            check_word_reg   <= check_word_next;
            content_bits_reg <= content_bits_next;
            packet_bits_reg  <= packet_bits_next;
            bytes_left_reg   <= bytes_left_next;
            pkt_uuid_hi_reg  <= pkt_uuid_hi_next;
            pkt_uuid_lo_reg  <= pkt_uuid_lo_next;
            scheme_reg       <= scheme_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_acc_reg          <= word_acc_next;
        str_uuid_hi_reg       <= str_uuid_hi_next;
        str_uuid_lo_reg       <= str_uuid_lo_next;
        pad_bytes_reg         <= pad_bytes_next;
        pad_zero_reg          <= pad_zero_next;
        content_left_reg      <= content_left_next;
        content_left_zero_reg <= content_left_zero_next;
        content_short_reg     <= content_short_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/tmpd_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one a cycle while pop is high.
// Depends on tmpd_pkg for result_t, res_push_t and the queue sizes.
`default_nettype none

module tmpd_fifo
    import tmpd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire res_push_t             push,
    input  wire logic                  pop,
    output logic                       head_valid,
    output result_t                    head,
    output logic      [FIFO_CNT_W-1:0] count
);

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_second;
    logic [FIFO_CNT_W-1:0] n_push;
    logic                  do_pop;

    assign head_valid    = count_reg != '0;
    assign head          = mem_reg[rd_ptr_reg];
    assign count         = count_reg;
    assign do_pop        = pop && head_valid;
    assign wr_ptr_second = wr_ptr_reg + FIFO_PTR_W'(1);
    assign n_push        = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push[FIFO_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + n_push - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem_reg[wr_ptr_second] <= push.r1;
        end
    end

endmodule

`default_nettype wire
